// ===== rtl/core/sc2a_pkg.sv =====
// Package with the ring size, item codes and scancode set 1 character tables.
package sc2a_pkg;

  localparam int RING_DEPTH = 256;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  typedef logic [RING_AW-1:0] ring_ptr_t;

  typedef enum logic [1:0] {
    FUNC_KEY  = 2'd0,
    FUNC_RAW  = 2'd1,
    FUNC_READ = 2'd2
  } func_t;

  localparam logic [7:0] BREAK_BIT  = 8'h80;
  localparam logic [6:0] KEY_LSHIFT = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT = 7'h36;
  localparam logic [7:0] CHR_CR     = 8'h0D;
  localparam logic [7:0] CHR_LF     = 8'h0A;

  localparam logic [7:0] PLAIN_MAP [128] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h2B, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] UPPER_MAP [128] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h2B, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  function automatic ring_ptr_t ptr_inc(input ring_ptr_t p);
    if (p == ring_ptr_t'(RING_DEPTH - 1)) begin
      return '0;
    end
    return p + ring_ptr_t'(1);
  endfunction

endpackage

// ===== rtl/core/scancode_to_ascii_fifo_top.sv =====
// Top level of the scancode to character ring buffer.
//
// A transaction is taken on every clock edge where start is high and busy is
// low; busy is high during reset and for the cycle after it, so one transaction
// can be issued every cycle. Each transaction is registered, decoded in the next
// cycle (shift tracking, table lookup, one ring write or one ring read), and a
// read of a non-empty ring returns its character on ascii_char with done high
// for exactly one cycle, registered after the decode cycle. The receiver
// cannot stall, so done must be sampled on that one cycle. The ring holds up to
// RING_DEPTH-1 characters in a single-port-write, single-read memory; a push
// into a full ring drops the oldest character, and a read of an empty ring
// returns nothing.
module scancode_to_ascii_fifo_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] func,
  input  logic [7:0] data_byte,
  output logic       done,
  output logic [7:0] ascii_char
);
  import sc2a_pkg::*;

  logic       in_valid;
  logic [1:0] func_q;
  logic [7:0] data_q;

  logic      shift_down, shift_down_next;
  ring_ptr_t write_ptr, write_ptr_next;
  ring_ptr_t read_ptr, read_ptr_next;

  logic [7:0] char_ring [RING_DEPTH];

  logic       push;
  logic       pop;
  logic [7:0] push_char;
  logic [7:0] key_char;
  ring_ptr_t  write_inc;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    func_q <= func;
    data_q <= data_byte;
  end

  assign key_char  = shift_down ? UPPER_MAP[data_q[6:0]] : PLAIN_MAP[data_q[6:0]];
  assign write_inc = ptr_inc(write_ptr);

  always_comb begin
    shift_down_next = shift_down;
    push            = 1'b0;
    pop             = 1'b0;
    push_char       = key_char;
    if (in_valid) begin
      unique case (func_q)
        FUNC_KEY: begin
          if ((data_q & BREAK_BIT) != 8'h00) begin
            if (data_q[6:0] == KEY_LSHIFT || data_q[6:0] == KEY_RSHIFT) begin
              shift_down_next = 1'b0;
            end
          end else if (data_q[6:0] == KEY_LSHIFT || data_q[6:0] == KEY_RSHIFT) begin
            shift_down_next = 1'b1;
          end else begin
            push = (key_char != 8'h00);
          end
        end
        FUNC_RAW: begin
          push      = 1'b1;
          push_char = (data_q == CHR_CR) ? CHR_LF : data_q;
        end
        FUNC_READ: begin
          pop = (write_ptr != read_ptr);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    write_ptr_next = write_ptr;
    read_ptr_next  = read_ptr;
    if (push) begin
      write_ptr_next = write_inc;
      if (write_inc == read_ptr) begin
        read_ptr_next = ptr_inc(read_ptr);
      end
    end else if (pop) begin
      read_ptr_next = ptr_inc(read_ptr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_down <= 1'b0;
      write_ptr  <= '0;
      read_ptr   <= '0;
      done       <= 1'b0;
    end else begin
      shift_down <= shift_down_next;
      write_ptr  <= write_ptr_next;
      read_ptr   <= read_ptr_next;
      done       <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      char_ring[write_ptr] <= push_char;
    end
  end

  always_ff @(posedge clk) begin
    ascii_char <= char_ring[read_ptr];
  end

  a_done_from_read: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(in_valid && func_q == FUNC_READ))
    else $error("done without a preceding read transaction");

  a_read_keeps_wptr: assert property (@(posedge clk) disable iff (rst)
    (in_valid && func_q == FUNC_READ) |=> $stable(write_ptr))
    else $error("write pointer moved on a read transaction");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (int'(write_ptr) < RING_DEPTH) && (int'(read_ptr) < RING_DEPTH))
    else $error("ring pointer beyond ring depth");

  a_push_not_empty: assert property (@(posedge clk) disable iff (rst)
    push |=> (write_ptr != read_ptr))
    else $error("ring empty after a push");

endmodule
